### rtl/abkf_pkg.sv
// Package: shared types, constants and arithmetic helpers for the angle/bias Kalman filter.
`default_nettype none
package abkf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_W  = 31;
    localparam int unsigned DT_W   = 25;
    localparam int unsigned FRAC_W = 24;

    localparam logic [REG_W-1:0] ANGLE_NOISE_RESET   = 31'd16777;
    localparam logic [REG_W-1:0] BIAS_NOISE_RESET    = 31'd50332;
    localparam logic [REG_W-1:0] MEASURE_NOISE_RESET = 31'd5033165;
    localparam logic signed [DATA_W-1:0] Q_ONE       = 32'sd16777216;

    localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // multiplier operand select
    localparam logic [2:0] MA_DT     = 3'd0;
    localparam logic [2:0] MA_DT2    = 3'd1;
    localparam logic [2:0] MA_K0     = 3'd2;
    localparam logic [2:0] MA_K1     = 3'd3;
    localparam logic [2:0] MA_AA     = 3'd4;
    localparam logic [2:0] MA_AB     = 3'd5;

    localparam logic [2:0] MB_BA     = 3'd0;
    localparam logic [2:0] MB_AB     = 3'd1;
    localparam logic [2:0] MB_BB     = 3'd2;
    localparam logic [2:0] MB_DT     = 3'd3;
    localparam logic [2:0] MB_RATE   = 3'd4;
    localparam logic [2:0] MB_Y      = 3'd5;
    localparam logic [2:0] MB_OM     = 3'd6;
    localparam logic [2:0] MB_AAOLD  = 3'd7;

    // product destinations
    localparam logic [3:0] PD_TBA  = 4'd0;
    localparam logic [3:0] PD_TAB  = 4'd1;
    localparam logic [3:0] PD_DT2  = 4'd2;
    localparam logic [3:0] PD_TBB  = 4'd3;
    localparam logic [3:0] PD_DBB  = 4'd4;
    localparam logic [3:0] PD_TA   = 4'd5;
    localparam logic [3:0] PD_KY0  = 4'd6;
    localparam logic [3:0] PD_KY1  = 4'd7;
    localparam logic [3:0] PD_NAA  = 4'd8;
    localparam logic [3:0] PD_NAB  = 4'd9;
    localparam logic [3:0] PD_KAA  = 4'd10;
    localparam logic [3:0] PD_KAB  = 4'd11;

    typedef struct packed {
        logic       load;
        logic       mul_go;
        logic [2:0] mul_a;
        logic [2:0] mul_b;
        logic [3:0] mul_dst;
        logic       prep_upd;
        logic       div_go;
        logic       div_sel;
        logic       commit_pred;
        logic       commit_upd;
    } abkf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic op;
    } abkf_sts_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/abkf_div.sv
// Serial signed divider: sat32((num << 24) / den), truncated toward zero, zero on den == 0.
`default_nettype none
module abkf_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [31:0]       num,
    input  wire logic signed [31:0]       den,
    output logic                          done,
    output logic signed [31:0]            quot
);
    import abkf_pkg::*;

    localparam int unsigned DIVIDEND_W = 56;
    localparam int unsigned CNT_W      = 6;

    logic [DIVIDEND_W-1:0] rem_q_reg, rem_q_next;
    logic [32:0]           part_reg, part_next;
    logic [31:0]           dmag_reg;
    logic                  neg_reg, zero_reg, busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [32:0]           trial;
    logic [32:0]           shifted;
    logic signed [65:0]    qs;

    always_comb begin
        shifted    = {part_reg[31:0], rem_q_reg[DIVIDEND_W-1]};
        trial      = shifted - {1'b0, dmag_reg};
        rem_q_next = {rem_q_reg[DIVIDEND_W-2:0], ~trial[32]};
        part_next  = trial[32] ? shifted : trial;
        if (zero_reg) begin
            qs = '0;
        end else if (neg_reg) begin
            qs = -$signed({10'd0, rem_q_reg});
        end else begin
            qs = $signed({10'd0, rem_q_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CNT_W'(DIVIDEND_W);
                rem_q_reg <= {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
                part_reg  <= '0;
                dmag_reg  <= den[31] ? 32'(-den) : 32'(den);
                neg_reg   <= num[31] ^ den[31];
                zero_reg  <= (den == 32'sd0);
            end else if (busy_reg) begin
                rem_q_reg <= rem_q_next;
                part_reg  <= part_next;
                cnt_reg   <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot = sat32(qs);
endmodule
`default_nettype wire

### rtl/abkf_datapath.sv
// Datapath: filter state, shared multiplier, serial divider and the combine sums.
`default_nettype none
module abkf_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire abkf_pkg::abkf_cmd_t    cmd,
    output abkf_pkg::abkf_sts_t         sts,
    input  wire logic                   in_op,
    input  wire logic signed [31:0]     in_sample,
    input  wire logic [24:0]            in_dt,
    input  wire logic [30:0]            angle_noise,
    input  wire logic [30:0]            bias_noise,
    input  wire logic [30:0]            measure_noise,
    output logic signed [31:0]          angle_out,
    output logic signed [31:0]          bias_out
);
    import abkf_pkg::*;

    logic signed [31:0] angle_reg, bias_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [31:0] samp_reg, dt_reg, y_reg, s_reg, k0_reg, k1_reg, om_reg;
    logic               op_reg;
    logic signed [31:0] tba_reg, tab_reg, dt2_reg, tbb_reg, dbb_reg, ta_reg;
    logic signed [31:0] ky0_reg, ky1_reg, naa_reg, nab_reg, kaa_reg, kab_reg;
    logic signed [31:0] ma, mb, mres;
    logic signed [63:0] prod_reg;
    logic [3:0]         dst_reg;
    logic               pv_reg;
    logic signed [31:0] rate;
    logic               div_done;
    logic signed [31:0] quot;
    logic signed [31:0] den_num;

    assign rate = sat32(66'(samp_reg) - 66'(bias_reg));

    always_comb begin
        case (cmd.mul_a)
            MA_DT:   ma = dt_reg;
            MA_DT2:  ma = dt2_reg;
            MA_K0:   ma = k0_reg;
            MA_K1:   ma = k1_reg;
            MA_AA:   ma = aa_reg;
            MA_AB:   ma = ab_reg;
            default: ma = '0;
        endcase
        case (cmd.mul_b)
            MB_BA:    mb = ba_reg;
            MB_AB:    mb = ab_reg;
            MB_BB:    mb = bb_reg;
            MB_DT:    mb = dt_reg;
            MB_RATE:  mb = rate;
            MB_Y:     mb = y_reg;
            MB_OM:    mb = om_reg;
            MB_AAOLD: mb = aa_reg;
            default:  mb = '0;
        endcase
    end

    // round: floor((p + 2^23) >> 24), then saturate
    assign mres = sat32(66'((66'(prod_reg) + 66'sd8388608) >>> FRAC_W));

    assign den_num = cmd.div_sel ? ba_reg : aa_reg;

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .num     (den_num),
        .den     (s_reg),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            bias_reg  <= '0;
            aa_reg    <= Q_ONE;
            ab_reg    <= '0;
            ba_reg    <= '0;
            bb_reg    <= Q_ONE;
            pv_reg    <= 1'b0;
        end else begin
            pv_reg <= cmd.mul_go;
            if (cmd.mul_go) begin
                prod_reg <= ma * mb;
                dst_reg  <= cmd.mul_dst;
            end
            if (pv_reg) begin
                case (dst_reg)
                    PD_TBA:  tba_reg <= mres;
                    PD_TAB:  tab_reg <= mres;
                    PD_DT2:  dt2_reg <= mres;
                    PD_TBB:  tbb_reg <= mres;
                    PD_DBB:  dbb_reg <= mres;
                    PD_TA:   ta_reg  <= mres;
                    PD_KY0:  ky0_reg <= mres;
                    PD_KY1:  ky1_reg <= mres;
                    PD_NAA:  naa_reg <= mres;
                    PD_NAB:  nab_reg <= mres;
                    PD_KAA:  kaa_reg <= mres;
                    PD_KAB:  kab_reg <= mres;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                op_reg   <= in_op;
                samp_reg <= in_sample;
                dt_reg   <= $signed({7'd0, in_dt});
            end
            if (cmd.prep_upd) begin
                y_reg <= sat32(66'(samp_reg) - 66'(angle_reg));
                s_reg <= sat32(66'(aa_reg) + $signed({35'd0, measure_noise}));
            end
            if (div_done) begin
                if (cmd.div_sel) begin
                    k1_reg <= quot;
                end else begin
                    k0_reg <= quot;
                    om_reg <= sat32(66'(Q_ONE) - 66'(quot));
                end
            end
            if (cmd.commit_pred) begin
                angle_reg <= sat32(66'(angle_reg) + 66'(ta_reg));
                aa_reg <= sat32(66'(aa_reg) - 66'(tba_reg) - 66'(tab_reg) + 66'(tbb_reg)
                                + $signed({35'd0, angle_noise}));
                ab_reg <= sat32(66'(ab_reg) - 66'(dbb_reg));
                ba_reg <= sat32(66'(ba_reg) - 66'(dbb_reg));
                bb_reg <= sat32(66'(bb_reg) + $signed({35'd0, bias_noise}));
            end
            if (cmd.commit_upd) begin
                angle_reg <= sat32(66'(angle_reg) + 66'(ky0_reg));
                bias_reg  <= sat32(66'(bias_reg) + 66'(ky1_reg));
                aa_reg    <= naa_reg;
                ab_reg    <= nab_reg;
                ba_reg    <= sat32(66'(ba_reg) - 66'(kaa_reg));
                bb_reg    <= sat32(66'(bb_reg) - 66'(kab_reg));
            end
        end
    end

    assign sts.div_done = div_done;
    assign sts.op       = op_reg;
    assign angle_out    = angle_reg;
    assign bias_out     = bias_reg;
endmodule
`default_nettype wire

### rtl/abkf_ctrl.sv
// Controller: sequences the multiplies, divides and commits of one predict or update word.
`default_nettype none
module abkf_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_fire,
    input  wire logic                   out_free,
    input  wire abkf_pkg::abkf_sts_t    sts,
    output abkf_pkg::abkf_cmd_t         cmd,
    output logic                        busy,
    output logic                        result_go
);
    import abkf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PMUL  = 4'd1;
    localparam logic [3:0] ST_PCOM  = 4'd2;
    localparam logic [3:0] ST_UPREP = 4'd3;
    localparam logic [3:0] ST_DIV0  = 4'd4;
    localparam logic [3:0] ST_W0    = 4'd5;
    localparam logic [3:0] ST_DIV1  = 4'd6;
    localparam logic [3:0] ST_W1    = 4'd7;
    localparam logic [3:0] ST_UMUL  = 4'd8;
    localparam logic [3:0] ST_UCOM  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        result_go  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL: begin
                if (sts.op == OP_UPDATE) begin
                    state_next = ST_UPREP;
                end else begin
                    cmd.mul_go = 1'b1;
                    step_next  = step_reg + 1'b1;
                    case (step_reg)
                        3'd0: begin cmd.mul_a = MA_DT; cmd.mul_b = MB_BA; cmd.mul_dst = PD_TBA; end
                        3'd1: begin cmd.mul_a = MA_DT; cmd.mul_b = MB_AB; cmd.mul_dst = PD_TAB; end
                        3'd2: begin cmd.mul_a = MA_DT; cmd.mul_b = MB_DT; cmd.mul_dst = PD_DT2; end
                        3'd3: begin cmd.mul_a = MA_DT; cmd.mul_b = MB_BB; cmd.mul_dst = PD_DBB; end
                        3'd4: begin cmd.mul_a = MA_DT; cmd.mul_b = MB_RATE; cmd.mul_dst = PD_TA; end
                        3'd5: begin cmd.mul_a = MA_DT2; cmd.mul_b = MB_BB; cmd.mul_dst = PD_TBB;
                              state_next = ST_PCOM; end
                        default: cmd.mul_go = 1'b0;
                    endcase
                end
            end
            ST_PCOM: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7) begin
                    cmd.commit_pred = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_UPREP: begin
                cmd.prep_upd = 1'b1;
                state_next   = ST_DIV0;
            end
            ST_DIV0: begin
                cmd.div_go = 1'b1;
                state_next = ST_W0;
            end
            ST_W0: begin
                if (sts.div_done) begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = 1'b1;
                state_next  = ST_W1;
            end
            ST_W1: begin
                cmd.div_sel = 1'b1;
                if (sts.div_done) begin
                    step_next  = '0;
                    state_next = ST_UMUL;
                end
            end
            ST_UMUL: begin
                cmd.mul_go = 1'b1;
                step_next  = step_reg + 1'b1;
                case (step_reg)
                    3'd0: begin cmd.mul_a = MA_K0; cmd.mul_b = MB_Y; cmd.mul_dst = PD_KY0; end
                    3'd1: begin cmd.mul_a = MA_K1; cmd.mul_b = MB_Y; cmd.mul_dst = PD_KY1; end
                    3'd2: begin cmd.mul_a = MA_AA; cmd.mul_b = MB_OM; cmd.mul_dst = PD_NAA; end
                    3'd3: begin cmd.mul_a = MA_AB; cmd.mul_b = MB_OM; cmd.mul_dst = PD_NAB; end
                    3'd4: begin cmd.mul_a = MA_K1; cmd.mul_b = MB_AAOLD; cmd.mul_dst = PD_KAA; end
                    3'd5: begin cmd.mul_a = MA_K1; cmd.mul_b = MB_AB; cmd.mul_dst = PD_KAB;
                          state_next = ST_UCOM; end
                    default: cmd.mul_go = 1'b0;
                endcase
            end
            ST_UCOM: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7) begin
                    cmd.commit_upd = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    result_go  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

### rtl/angle_bias_kalman_filter_unit.sv
// Top level: angle and gyro-bias Kalman filter with stream ports and a write-only register port.
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_       | in  | [31:0] sample_value, [56:32] time_step       | [0] operation
//  m_       | out | [31:0] angle_estimate, [63:32] bias_estimate | -
//  cfg      | in  | 0 angle noise, 1 bias noise, 2 measure noise  | -
// An update word runs two 56-step serial divides.
// One shared 32x32 multiplier does all products, one per cycle, registered.
// The result register holds a word while m_tready is low; a new input word is taken
// once the previous result has moved into it. aresetn is synchronous, active low.
`default_nettype none
module angle_bias_kalman_filter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // sample_value, time_step
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // angle_estimate, bias_estimate
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);
    import abkf_pkg::*;

    logic [30:0]        an_reg, bn_reg, mn_reg;
    abkf_cmd_t          cmd;
    abkf_sts_t          sts;
    logic               busy, result_go, in_fire, out_free;
    logic signed [31:0] angle_out, bias_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            an_reg <= ANGLE_NOISE_RESET;
            bn_reg <= BIAS_NOISE_RESET;
            mn_reg <= MEASURE_NOISE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ANGLE_NOISE:   an_reg <= cfg_data;
                CFG_BIAS_NOISE:    bn_reg <= cfg_data;
                CFG_MEASURE_NOISE: mn_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    abkf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_free  (out_free),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .result_go (result_go)
    );

    abkf_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (s_tuser),
        .in_sample     ($signed(s_tdata[31:0])),
        .in_dt         (s_tdata[56:32]),
        .angle_noise   (an_reg),
        .bias_noise    (bn_reg),
        .measure_noise (mn_reg),
        .angle_out     (angle_out),
        .bias_out      (bias_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else begin
            if (result_go) begin
                m_tvalid <= 1'b1;
                m_tdata  <= {bias_out, angle_out};
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("input taken while busy");
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        result_go |=> !busy && m_tvalid) else $error("result not posted");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result lost under stall");
    a_single_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit_pred && cmd.commit_upd)) else $error("double commit");
endmodule
`default_nettype wire

### dv/tb_angle_bias_kalman_filter_unit.sv
// Testbench for the angle/bias Kalman filter: directed and random predict/update words checked
// against a bit-accurate fixed-point model, with random idling on both stream sides.
`default_nettype none
module tb_angle_bias_kalman_filter_unit;
    import abkf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    angle_bias_kalman_filter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // filter state mirror
    longint f_angle, f_bias, p_aa, p_ab, p_ba, p_bb;
    longint q_angle, q_bias, r_meas;
    logic [31:0] exp_angle_q[$];
    logic [31:0] exp_bias_q[$];
    int errors = 0;
    bit stall_rx = 1'b0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul24(input longint a, input longint b);
        return clamp32((a * b + 64'sd8388608) >>> 24);
    endfunction

    function automatic longint qdiv24(input longint n, input longint d);
        if (d == 0) return 0;
        return clamp32((n * 64'sd16777216) / d);
    endfunction

    task automatic filter_step(input logic op, input logic [31:0] sv, input logic [24:0] dt_u);
        longint z, dt, rate, tba, tab, tbb, dbb, y, s, k0, k1, om, aa0, ab0;
        z = longint'(signed'(sv));
        dt = longint'(dt_u);
        if (op == OP_PREDICT) begin
            rate = clamp32(z - f_bias);
            tba = qmul24(dt, p_ba);
            tab = qmul24(dt, p_ab);
            tbb = qmul24(qmul24(dt, dt), p_bb);
            dbb = qmul24(dt, p_bb);
            f_angle = clamp32(f_angle + qmul24(dt, rate));
            p_aa = clamp32(p_aa - tba - tab + tbb + q_angle);
            p_ab = clamp32(p_ab - dbb);
            p_ba = clamp32(p_ba - dbb);
            p_bb = clamp32(p_bb + q_bias);
        end else begin
            y = clamp32(z - f_angle);
            s = clamp32(p_aa + r_meas);
            k0 = qdiv24(p_aa, s);
            k1 = qdiv24(p_ba, s);
            om = clamp32(64'sd16777216 - k0);
            aa0 = p_aa;
            ab0 = p_ab;
            f_angle = clamp32(f_angle + qmul24(k0, y));
            f_bias = clamp32(f_bias + qmul24(k1, y));
            p_aa = qmul24(aa0, om);
            p_ab = qmul24(ab0, om);
            p_ba = clamp32(p_ba - qmul24(k1, aa0));
            p_bb = clamp32(p_bb - qmul24(k1, ab0));
        end
        exp_angle_q.push_back(f_angle[31:0]);
        exp_bias_q.push_back(f_bias[31:0]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        return $urandom_range(0, 3);
    endfunction

    // receiver: random stalls while stall_rx is set, checks every word
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (exp_angle_q.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
                end else begin
                    if (m_tdata[31:0] !== exp_angle_q[0])
                        report_mismatch("angle", m_tdata[31:0], exp_angle_q[0]);
                    if (m_tdata[63:32] !== exp_bias_q[0])
                        report_mismatch("bias", m_tdata[63:32], exp_bias_q[0]);
                    void'(exp_angle_q.pop_front());
                    void'(exp_bias_q.pop_front());
                end
            end
            if (stall_rx) begin
                g = pick_gap();
                m_tready <= (g == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic op, input logic [31:0] sv, input logic [24:0] dt);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, dt, sv};
        do @(posedge aclk); while (!s_tready);
        filter_step(op, sv, dt);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (exp_angle_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_ANGLE_NOISE) q_angle = longint'(val);
        else if (idx == CFG_BIAS_NOISE) q_bias = longint'(val);
        else if (idx == CFG_MEASURE_NOISE) r_meas = longint'(val);
    endtask

    function automatic logic [24:0] rand_dt();
        case ($urandom_range(0, 9))
            0: return 25'd0;
            1: return 25'd16777216;
            2: return 25'h1ffffff;
            3: return 25'($urandom);
            default: return 25'($urandom_range(1000, 400000));
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'(int'($urandom_range(0, 60000000)) - 30000000);
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_word(OP_PREDICT, 32'h0, 25'd0);
        send_word(OP_PREDICT, 32'h7fffffff, 25'd16777216);
        send_word(OP_PREDICT, 32'h80000000, 25'h1ffffff);
        send_word(OP_UPDATE, 32'h7fffffff, 25'h1ffffff);
        send_word(OP_UPDATE, 32'h80000000, 25'd0);
        send_word(OP_PREDICT, 32'h01000000, 25'd167772);
        send_word(OP_UPDATE, 32'h00800000, 25'd5);
        send_word(OP_PREDICT, 32'hffffffff, 25'h0aaaaaa);
        send_word(OP_UPDATE, 32'h55555555, 25'h1555555);
        send_word(OP_UPDATE, 32'haaaaaaaa, 25'h0);
        drain();
    endtask

    task automatic test_zero_measure_noise();
        // zero and negative innovation variance paths
        write_reg(CFG_MEASURE_NOISE, 31'd0);
        write_reg(CFG_ANGLE_NOISE, 31'h7fffffff);
        write_reg(CFG_BIAS_NOISE, 31'h7fffffff);
        send_word(OP_PREDICT, 32'h00100000, 25'd16777216);
        send_word(OP_UPDATE, 32'h00200000, 25'd0);
        send_word(OP_PREDICT, 32'h80000000, 25'h1ffffff);
        send_word(OP_UPDATE, 32'h7fffffff, 25'd0);
        send_word(OP_UPDATE, 32'h0, 25'd0);
        drain();
        write_reg(CFG_ANGLE_NOISE, 31'd0);
        write_reg(CFG_BIAS_NOISE, 31'd0);
        write_reg(CFG_MEASURE_NOISE, 31'h7fffffff);
        send_word(OP_PREDICT, 32'h00300000, 25'd16777);
        send_word(OP_UPDATE, 32'hff000000, 25'd0);
        drain();
    endtask

    task automatic test_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i % 120 == 0) begin
                drain();
                write_reg(CFG_ANGLE_NOISE, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                                        : 31'($urandom_range(0, 200000)));
                write_reg(CFG_BIAS_NOISE, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                                       : 31'($urandom_range(0, 200000)));
                write_reg(CFG_MEASURE_NOISE, ($urandom_range(0, 5) == 0) ? 31'($urandom)
                                                                          : 31'($urandom_range(1, 20000000)));
            end
            if (i % 4 == 3) send_word(OP_UPDATE, rand_sample(), 25'($urandom));
            else if ($urandom_range(0, 9) == 0) send_word(OP_UPDATE, rand_sample(), rand_dt());
            else send_word(OP_PREDICT, rand_sample(), rand_dt());
        end
        drain();
    endtask

    initial begin
        f_angle = 0; f_bias = 0; p_aa = 16777216; p_ab = 0; p_ba = 0; p_bb = 16777216;
        q_angle = 16777; q_bias = 50332; r_meas = 5033165;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        stall_rx = 1'b1;
        test_zero_measure_noise();
        test_random(500);
        stall_rx = 1'b0;
        test_random(150);
        stall_rx = 1'b1;
        test_random(450);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
